// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by csn_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/csn_pkg.sv =====
// ---------------------------------------------------------------------------
// csn_pkg
// Types, codes and the face geometry table of the cube-sphere tile neighbor.
// ---------------------------------------------------------------------------
package csn_pkg;

   localparam int FACE_W = 3;
   localparam int IDX_W  = 6;
   localparam int DIR_W  = 2;
   localparam int TILES_ACROSS_DEFAULT = 64;

   typedef enum logic [FACE_W-1:0] {
      FACE_PX = 3'd0,
      FACE_NX = 3'd1,
      FACE_PY = 3'd2,
      FACE_NY = 3'd3,
      FACE_PZ = 3'd4,
      FACE_NZ = 3'd5
   } face_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_POS_U = 2'd0,
      DIR_NEG_U = 2'd1,
      DIR_POS_V = 2'd2,
      DIR_NEG_V = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      axis_type main_axis;
      logic     main_neg;
      axis_type u_axis;
      logic     u_neg;
      axis_type v_axis;
      logic     v_neg;
   } face_geom_type;

   localparam face_geom_type FACE_TABLE [6] = '{
      '{AXIS_X, 1'b0, AXIS_Y, 1'b0, AXIS_Z, 1'b0},
      '{AXIS_X, 1'b1, AXIS_Z, 1'b0, AXIS_Y, 1'b0},
      '{AXIS_Y, 1'b0, AXIS_Z, 1'b0, AXIS_X, 1'b0},
      '{AXIS_Y, 1'b1, AXIS_X, 1'b0, AXIS_Z, 1'b0},
      '{AXIS_Z, 1'b0, AXIS_X, 1'b0, AXIS_Y, 1'b0},
      '{AXIS_Z, 1'b1, AXIS_Y, 1'b0, AXIS_X, 1'b0}
   };

   typedef struct packed {
      logic [FACE_W-1:0] tile_face;
      logic [IDX_W-1:0]  tile_u;
      logic [IDX_W-1:0]  tile_v;
      logic [DIR_W-1:0]  direction;
   } req_item_type;

   typedef struct packed {
      logic [FACE_W-1:0] next_face;
      logic [IDX_W-1:0]  next_u;
      logic [IDX_W-1:0]  next_v;
   } rsp_item_type;

endpackage

// ===== rtl/csn_chan_if.sv =====
// ---------------------------------------------------------------------------
// csn channel interfaces
// Valid/ready channels for tile requests and neighbor responses.
// ---------------------------------------------------------------------------
interface csn_req_if;
   logic                       valid;
   logic                       ready;
   logic [csn_pkg::FACE_W-1:0] tile_face;
   logic [csn_pkg::IDX_W-1:0]  tile_u;
   logic [csn_pkg::IDX_W-1:0]  tile_v;
   logic [csn_pkg::DIR_W-1:0]  direction;

   modport source (output valid, tile_face, tile_u, tile_v, direction, input ready);
   modport sink   (input valid, tile_face, tile_u, tile_v, direction, output ready);
endinterface

interface csn_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [csn_pkg::FACE_W-1:0] next_face;
   logic [csn_pkg::IDX_W-1:0]  next_u;
   logic [csn_pkg::IDX_W-1:0]  next_v;

   modport source (output valid, next_face, next_u, next_v, input ready);
   modport sink   (input valid, next_face, next_u, next_v, output ready);
endinterface

// ===== rtl/csn_step.sv =====
// ---------------------------------------------------------------------------
// csn_step
// Combinational neighbor lookup: tile center to cube coordinates, one step,
// target face by largest magnitude, then back to clamped face indices.
// ---------------------------------------------------------------------------
module csn_step #(
   parameter int TILES_ACROSS = csn_pkg::TILES_ACROSS_DEFAULT
) (
   input  csn_pkg::req_item_type req_item,
   output csn_pkg::rsp_item_type rsp_item
);
   import csn_pkg::*;

   // coordinates span -(N+1)..N+1 in half-tile units
   localparam int CW_MIN = $clog2(TILES_ACROSS + 3) + 1;
   localparam int CW     = (CW_MIN > IDX_W + 1) ? CW_MIN : IDX_W + 1;
   localparam logic signed [CW-1:0] N_S   = CW'(TILES_ACROSS);
   localparam logic signed [CW-1:0] NM1_S = CW'(TILES_ACROSS - 1);
   localparam logic signed [CW:0]   N_X   = (CW+1)'(TILES_ACROSS);

   face_type               face_c;
   face_geom_type          geom;
   face_geom_type          ngeom;
   logic signed [CW-1:0]   u_c;
   logic signed [CW-1:0]   v_c;
   logic signed [CW-1:0]   main_val;
   logic signed [CW-1:0]   u_val;
   logic signed [CW-1:0]   v_val;
   logic signed [CW-1:0]   pos [3];
   logic signed [CW-1:0]   moved [3];
   logic [CW-1:0]          mag [3];
   axis_type               move_axis;
   logic                   move_neg;
   logic                   dir_pos;
   logic signed [CW-1:0]   step;
   face_type               nface;
   logic signed [CW-1:0]   cu;
   logic signed [CW-1:0]   cv;
   logic [IDX_W-1:0]       nu;
   logic [IDX_W-1:0]       nv;

   function automatic logic signed [CW-1:0] apply_sign(logic signed [CW-1:0] x, logic neg);
      return neg ? -x : x;
   endfunction

   // (c + N) / 2, clamped to 0..N-1, then cut to the field width
   function automatic logic [IDX_W-1:0] face_index(logic signed [CW-1:0] c);
      logic signed [CW:0] s;
      logic [CW:0]        idx;
      s = {c[CW-1], c} + N_X;
      if (s < 0) begin
         s = '0;
      end
      idx = {1'b0, s[CW:1]};
      if (idx > (CW+1)'(TILES_ACROSS - 1)) begin
         idx = (CW+1)'(TILES_ACROSS - 1);
      end
      return idx[IDX_W-1:0];
   endfunction

   always_comb begin
      face_c = (req_item.tile_face > FACE_NZ) ? FACE_NZ : face_type'(req_item.tile_face);
      geom   = FACE_TABLE[face_c];

      u_c = CW'(req_item.tile_u);
      if (u_c > NM1_S) begin
         u_c = NM1_S;
      end
      v_c = CW'(req_item.tile_v);
      if (v_c > NM1_S) begin
         v_c = NM1_S;
      end

      main_val = apply_sign(N_S, geom.main_neg);
      u_val    = apply_sign((u_c <<< 1) + CW'(1) - N_S, geom.u_neg);
      v_val    = apply_sign((v_c <<< 1) + CW'(1) - N_S, geom.v_neg);

      for (int a = 0; a < 3; a++) begin
         if (geom.main_axis == axis_type'(a)) begin
            pos[a] = main_val;
         end else if (geom.u_axis == axis_type'(a)) begin
            pos[a] = u_val;
         end else begin
            pos[a] = v_val;
         end
      end

      unique case (dir_type'(req_item.direction))
         DIR_POS_U: begin move_axis = geom.u_axis; move_neg = geom.u_neg; dir_pos = 1'b1; end
         DIR_NEG_U: begin move_axis = geom.u_axis; move_neg = geom.u_neg; dir_pos = 1'b0; end
         DIR_POS_V: begin move_axis = geom.v_axis; move_neg = geom.v_neg; dir_pos = 1'b1; end
         default:   begin move_axis = geom.v_axis; move_neg = geom.v_neg; dir_pos = 1'b0; end
      endcase
      step = (dir_pos ^ move_neg) ? CW'(2) : -CW'(2);

      for (int a = 0; a < 3; a++) begin
         moved[a] = pos[a] + ((move_axis == axis_type'(a)) ? step : '0);
         mag[a]   = moved[a][CW-1] ? CW'(-moved[a]) : CW'(moved[a]);
      end

      // ties go to x, then y
      if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
         nface = moved[0][CW-1] ? FACE_NX : FACE_PX;
      end else if (mag[1] >= mag[2]) begin
         nface = moved[1][CW-1] ? FACE_NY : FACE_PY;
      end else begin
         nface = moved[2][CW-1] ? FACE_NZ : FACE_PZ;
      end

      ngeom = FACE_TABLE[nface];
      cu    = apply_sign(moved[ngeom.u_axis], ngeom.u_neg);
      cv    = apply_sign(moved[ngeom.v_axis], ngeom.v_neg);
      nu    = face_index(cu);
      nv    = face_index(cv);

      rsp_item.next_face = nface;
      rsp_item.next_u    = nu;
      rsp_item.next_v    = nv;
   end

endmodule

// ===== rtl/cube_sphere_tile_neighbor.sv =====
// ---------------------------------------------------------------------------
// cube_sphere_tile_neighbor
// Neighbor of a cube-sphere tile one step along u or v, across face edges.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries a tile (face, u, v) and a step direction; rsp_chan
//   returns the neighboring tile (face, u, v). Both are valid/ready; a
//   transaction completes on a clock edge with valid and ready high.
//   Every request yields exactly one response, in request order.
//   A request transaction loads the input register; the lookup logic feeds
//   the output register, which drives rsp_chan. Throughput: one transaction
//   per cycle while the receiver is ready, set by the single pass through
//   the lookup logic.
//   When the receiver stalls the response register holds its value and the
//   input register still takes one more transaction if it is empty; after
//   that req ready drops until the output drains.
//   Reset (synchronous) empties both registers; no configuration exists.
//   Face codes 6 and 7 act as face 5; indices of N or more act as N-1.
// ---------------------------------------------------------------------------
module cube_sphere_tile_neighbor #(
   parameter int TILES_ACROSS = csn_pkg::TILES_ACROSS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   csn_req_if.sink   req_chan,
   csn_rsp_if.source rsp_chan
);
   import csn_pkg::*;

   req_item_type req_ff, req_in;
   logic         req_valid_ff, req_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type lookup;
   logic         rsp_load;
   logic         req_load;

   csn_step #(
      .TILES_ACROSS(TILES_ACROSS)
   ) u_step (
      .req_item(req_ff),
      .rsp_item(lookup)
   );

   assign rsp_load = !rsp_valid_ff || rsp_chan.ready;
   assign req_load = !req_valid_ff || rsp_load;

   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = lookup;
         rsp_valid_in = req_valid_ff;
      end
      if (req_load) begin
         req_in.tile_face = req_chan.tile_face;
         req_in.tile_u    = req_chan.tile_u;
         req_in.tile_v    = req_chan.tile_v;
         req_in.direction = req_chan.direction;
         req_valid_in     = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready     = req_load;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.next_face = rsp_ff.next_face;
   assign rsp_chan.next_u    = rsp_ff.next_u;
   assign rsp_chan.next_v    = rsp_ff.next_v;

endmodule

// ===== rtl/csn_checker.sv =====
// ---------------------------------------------------------------------------
// csn_checker
// Port-level checks of the tile neighbor block, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csn_checker #(
   parameter int TILES_ACROSS = csn_pkg::TILES_ACROSS_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [csn_pkg::FACE_W-1:0] next_face,
   input logic [csn_pkg::IDX_W-1:0]  next_u,
   input logic [csn_pkg::IDX_W-1:0]  next_v
);
   import csn_pkg::*;

   localparam int IDX_LIM = (TILES_ACROSS < 64) ? TILES_ACROSS - 1 : 63;
   localparam logic [IDX_W-1:0] IDX_LIM_V = IDX_W'(IDX_LIM);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(next_face) && $stable(next_u) && $stable(next_v), "response changed while stalled")

   `ASSERT_IMPL(a_face_range, clock, reset, rsp_valid, next_face <= FACE_NZ, "response face out of range")

   `ASSERT_IMPL(a_index_range, clock, reset, rsp_valid, next_u <= IDX_LIM_V && next_v <= IDX_LIM_V, "response index out of range")

   `ASSERT_NEXT(a_latency, clock, reset, req_fire ##1 rsp_ready, rsp_valid, "response missing two cycles after request")

   `ASSERT_IMPL(a_no_phantom, clock, reset, $rose(rsp_valid), $past(req_fire, 2), "response without a request")

endmodule

bind cube_sphere_tile_neighbor csn_checker #(
   .TILES_ACROSS(TILES_ACROSS)
) u_csn_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .next_face(rsp_chan.next_face),
   .next_u   (rsp_chan.next_u),
   .next_v   (rsp_chan.next_v)
);

// ===== dv/csn_neighbor_checker.sv =====
// ---------------------------------------------------------------------------
// csn_neighbor_checker
// Watches the request and response channels of the cube-sphere tile
// neighbor, predicts the neighboring tile of every accepted request and
// compares each response against the oldest prediction, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module csn_neighbor_checker #(
   parameter int TILES_ACROSS = csn_pkg::TILES_ACROSS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   csn_req_if   req_chan,
   csn_rsp_if   rsp_chan,
   output int   mismatch_count,
   output int   results_checked
);
   import csn_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // per face: main axis and sign, signed u and v axes
   localparam int MAIN_AXIS [6] = '{AXIS_X, AXIS_X, AXIS_Y, AXIS_Y, AXIS_Z, AXIS_Z};
   localparam int MAIN_SIGN [6] = '{1, -1, 1, -1, 1, -1};
   localparam int U_AXIS    [6] = '{AXIS_Y, AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y};
   localparam int U_SIGN    [6] = '{1, 1, 1, 1, 1, 1};
   localparam int V_AXIS    [6] = '{AXIS_Z, AXIS_Y, AXIS_X, AXIS_Z, AXIS_Y, AXIS_X};
   localparam int V_SIGN    [6] = '{1, 1, 1, 1, 1, 1};

   rsp_item_type expected_tiles [$];

   // half-tile coordinate along a face axis -> tile index, clamped
   function automatic int face_index(int coord);
      int s;
      s = coord + TILES_ACROSS;
      if (s < 0) s = 0;
      s = s / 2;
      if (s > TILES_ACROSS - 1) s = TILES_ACROSS - 1;
      return s;
   endfunction

   function automatic rsp_item_type neighbor_of(req_item_type item);
      int n, face, u, v, step, dest;
      int pos [3];
      int mag [3];
      rsp_item_type tile;
      n = TILES_ACROSS;
      face = (item.tile_face > FACE_NZ) ? FACE_NZ : int'(item.tile_face);
      u = item.tile_u;
      v = item.tile_v;
      if (u > n - 1) u = n - 1;
      if (v > n - 1) v = n - 1;
      // tile center on the cube, in half-tile units
      pos[MAIN_AXIS[face]] = MAIN_SIGN[face] * n;
      pos[U_AXIS[face]]    = U_SIGN[face] * (2 * u + 1 - n);
      pos[V_AXIS[face]]    = V_SIGN[face] * (2 * v + 1 - n);
      step = (item.direction == DIR_POS_U || item.direction == DIR_POS_V) ? 2 : -2;
      if (item.direction == DIR_POS_U || item.direction == DIR_NEG_U)
         pos[U_AXIS[face]] += step * U_SIGN[face];
      else
         pos[V_AXIS[face]] += step * V_SIGN[face];
      for (int i = 0; i < 3; i++) mag[i] = (pos[i] < 0) ? -pos[i] : pos[i];
      // dominant axis picks the face; ties go x, then y
      if (mag[0] >= mag[1] && mag[0] >= mag[2])
         dest = (pos[0] >= 0) ? FACE_PX : FACE_NX;
      else if (mag[1] >= mag[2])
         dest = (pos[1] >= 0) ? FACE_PY : FACE_NY;
      else
         dest = (pos[2] >= 0) ? FACE_PZ : FACE_NZ;
      tile.next_face = FACE_W'(dest);
      tile.next_u    = IDX_W'(face_index(pos[U_AXIS[dest]] * U_SIGN[dest]));
      tile.next_v    = IDX_W'(face_index(pos[V_AXIS[dest]] * V_SIGN[dest]));
      return tile;
   endfunction

   always @(posedge clock) begin : watch
      req_item_type item;
      rsp_item_type got, want;
      if (reset) begin
         expected_tiles.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            item = {req_chan.tile_face, req_chan.tile_u, req_chan.tile_v,
                    req_chan.direction};
            expected_tiles.push_back(neighbor_of(item));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = {rsp_chan.next_face, rsp_chan.next_u, rsp_chan.next_v};
            if (expected_tiles.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected response face %0d u %0d v %0d", $realtime,
                           got.next_face, got.next_u, got.next_v);
            end else begin
               want = expected_tiles.pop_front();
               if (got.next_face !== want.next_face || got.next_u !== want.next_u ||
                   got.next_v !== want.next_v) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: neighbor mismatch: expected face %0d u %0d v %0d, got face %0d u %0d v %0d",
                              $realtime, want.next_face, want.next_u, want.next_v,
                              got.next_face, got.next_u, got.next_v);
               end
            end
            results_checked++;
         end
      end
   end

endmodule

// ===== dv/tb_cube_sphere_tile_neighbor.sv =====
// ---------------------------------------------------------------------------
// tb_cube_sphere_tile_neighbor
// Drives tile requests into the cube-sphere tile neighbor: edge crossings on
// every face and direction, then random tiles biased toward face edges under
// several sender/receiver idle mixes, including a long receiver hold-off.
// A checker beside the block predicts and compares every response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cube_sphere_tile_neighbor;
   import csn_pkg::*;

   localparam int TILES_ACROSS  = TILES_ACROSS_DEFAULT;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 600;
   localparam int HOLD_CYCLES   = 80;
   localparam int NUM_PHASES    = 4;
   localparam int IDLE_PCT  [NUM_PHASES] = '{0, 86, 0, 30};
   localparam int STALL_PCT [NUM_PHASES] = '{0, 0, 86, 30};

   logic clock = 1'b0;
   logic reset = 1'b1;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int mismatch_count;
   int results_checked;

   csn_req_if req_chan ();
   csn_rsp_if rsp_chan ();

   cube_sphere_tile_neighbor #(.TILES_ACROSS(TILES_ACROSS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   csn_neighbor_checker #(.TILES_ACROSS(TILES_ACROSS)) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mismatch_count  (mismatch_count),
      .results_checked (results_checked)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cube_sphere_tile_neighbor regression: fail");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_chan.ready <= 1'b0;
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_tile(input logic [FACE_W-1:0] face, input logic [IDX_W-1:0] u,
                            input logic [IDX_W-1:0] v, input logic [DIR_W-1:0] dir);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.tile_face <= face;
      req_chan.tile_u    <= u;
      req_chan.tile_v    <= v;
      req_chan.direction <= dir;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // weighted toward edge tiles, where the face crossings happen
   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(4))
         0: return IDX_W'($urandom_range(1));
         1: return IDX_W'(TILES_ACROSS - 1 - $urandom_range(1));
         default: return IDX_W'($urandom_range(TILES_ACROSS - 1));
      endcase
   endfunction

   task automatic send_random();
      send_tile(FACE_W'($urandom_range(7)), pick_index(), pick_index(),
                DIR_W'($urandom_range(3)));
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      wait (results_checked == items_sent);
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.tile_face <= '0;
      req_chan.tile_u    <= '0;
      req_chan.tile_v    <= '0;
      req_chan.direction <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // step off every edge of every face
      for (int f = FACE_PX; f <= FACE_NZ; f++) begin
         send_tile(FACE_W'(f), '0, IDX_W'(TILES_ACROSS / 2), DIR_NEG_U);
         send_tile(FACE_W'(f), IDX_W'(TILES_ACROSS - 1), IDX_W'(TILES_ACROSS / 2), DIR_POS_U);
         send_tile(FACE_W'(f), IDX_W'(TILES_ACROSS / 2), '0, DIR_NEG_V);
         send_tile(FACE_W'(f), IDX_W'(TILES_ACROSS / 2), IDX_W'(TILES_ACROSS - 1), DIR_POS_V);
      end
      // out-of-range face codes alias the last face
      send_tile(3'd6, IDX_W'(TILES_ACROSS - 1), IDX_W'(TILES_ACROSS - 1), DIR_POS_U);
      send_tile(3'd7, '0, '0, DIR_NEG_V);
      drain();

      // receiver holds off while requests keep coming: input must back up
      hold_requests <= hold_requests + 1;
      repeat (20) send_random();
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_idle_pct  = IDLE_PCT[phase];
         rsp_stall_pct = STALL_PCT[phase];
         repeat (RANDOM_ITEMS / NUM_PHASES) send_random();
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_checked == items_sent)
         $display("cube_sphere_tile_neighbor regression: pass");
      else
         $display("cube_sphere_tile_neighbor regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/csn_pkg.sv
rtl/csn_chan_if.sv
rtl/csn_step.sv
rtl/cube_sphere_tile_neighbor.sv
rtl/csn_checker.sv
dv/csn_neighbor_checker.sv
dv/tb_cube_sphere_tile_neighbor.sv
